// ===== hdl/cfst_pkg.sv =====
// Shared types, constants and the CRC-8 byte function for the CRC-framed serial master.
// No dependencies; every other file of the block uses this package.
package cfst_pkg;

  // Frame geometry.
  localparam int FRAME_BITS = 32;
  localparam int CNT_W      = $clog2(FRAME_BITS + 1);
  localparam int WORD_W     = 32;
  localparam int CMD_W      = 24;
  localparam int DATA_CNT_W = $clog2(CMD_W + 1);
  localparam int CRC_W      = 8;

  // Configuration port.
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam bit REG_CRC_POLY = 1'b0;
  localparam logic [CRC_W-1:0] POLY_RESET = 8'h1D;

  // Transaction modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [CMD_W-1:0] command;
    logic             rx_bit;
  } in_item_t;

  typedef struct packed {
    logic              tx_bit;
    logic [WORD_W-1:0] rx_word;
    logic              frame_done;
    logic              misuse;
  } out_item_t;

  // Controls from the frame sequencer to the CRC engine.
  typedef struct packed {
    logic start;
    logic shift;
  } crc_ctrl_t;

  // One byte of MSB-first CRC-8: xor the byte in, then eight shift steps.
  function automatic logic [CRC_W-1:0] crc8_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [CRC_W-1:0] data,
                                                 input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] c;
    c = crc ^ data;
    for (int j = 0; j < CRC_W; j++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/cfst_crc_engine.sv =====
// CRC-8 engine: one command byte per cycle, then the check byte shifts out MSB first.
// Depends on cfst_pkg.
module cfst_crc_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  cfst_pkg::crc_ctrl_t        ctrl,
  input  logic [cfst_pkg::CMD_W-1:0] command,
  input  logic [cfst_pkg::CRC_W-1:0] poly,
  output logic                       crc_msb
);

  logic [cfst_pkg::CRC_W-1:0]   crc;
  logic [cfst_pkg::CRC_W-1:0]   poly_lat;
  logic [2*cfst_pkg::CRC_W-1:0] pend;
  logic [1:0]                   pend_cnt;

  assign crc_msb = crc[cfst_pkg::CRC_W-1];

  // The low command byte is folded in on the start cycle; the other two follow,
  // one per cycle, well before the first check bit is due on the line.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
      crc      <= '0;
    end else if (ctrl.start) begin
      crc      <= cfst_pkg::crc8_byte('0, command[cfst_pkg::CRC_W-1:0], poly);
      pend     <= command[cfst_pkg::CMD_W-1:cfst_pkg::CRC_W];
      poly_lat <= poly;
      pend_cnt <= 2'd2;
    end else if (pend_cnt != 2'd0) begin
      crc      <= cfst_pkg::crc8_byte(crc, pend[cfst_pkg::CRC_W-1:0], poly_lat);
      pend     <= {{cfst_pkg::CRC_W{1'b0}}, pend[2*cfst_pkg::CRC_W-1:cfst_pkg::CRC_W]};
      pend_cnt <= pend_cnt - 2'd1;
    end else if (ctrl.shift) begin
      crc <= {crc[cfst_pkg::CRC_W-2:0], 1'b0};
    end
  end

endmodule

// ===== hdl/cfst_out_reg.sv =====
// Result register: holds one result transaction until the consumer takes it.
// Depends on cfst_pkg.
module cfst_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  cfst_pkg::out_item_t load_data,
  output logic                load_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output cfst_pkg::out_item_t out_data
);

  // A new result may enter when the register is empty or when the held one leaves in the same cycle.
  assign load_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== hdl/crc_framed_serial_transfer.sv =====
// Top level of the CRC-framed serial master: frame sequencer, APB register and result stage.
// Depends on cfst_pkg, cfst_crc_engine and cfst_out_reg.
//
// A start transaction loads a 24-bit command, sent low byte first, followed by a CRC-8
// over those bytes (MSB first, init 0, polynomial from crc_poly at byte address 0,
// reset 0x1D). Each tick transaction then returns the outgoing bit and shifts in rx_bit;
// the tick that ends the frame returns the received word with frame_done set. A start
// while a frame is running, or a tick while idle, is ignored and returns misuse. Every
// transaction yields one registered result, in the cycle after acceptance; a
// transaction is accepted every cycle as long as the result register drains, so the
// rate is one per cycle. The CRC engine folds in one command byte per cycle, starting
// at the edge that accepts the start, and is done long before any check bit is needed.
module crc_framed_serial_transfer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cfst_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cfst_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfst_pkg::PADDR_W-1:0] paddr,
  input  logic [cfst_pkg::PDATA_W-1:0] pwdata,
  output logic [cfst_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  logic [cfst_pkg::CRC_W-1:0]      crc_poly;
  logic [cfst_pkg::CMD_W-1:0]      data_sr;
  logic [cfst_pkg::DATA_CNT_W-1:0] data_cnt;
  logic [cfst_pkg::WORD_W-1:0]     rx_shift;
  logic [cfst_pkg::CNT_W-1:0]      bits_left;
  logic                            busy;

  logic [cfst_pkg::WORD_W-1:0] rx_shift_next;
  logic                        accept;
  logic                        do_start;
  logic                        do_tick;
  logic                        crc_msb;
  cfst_pkg::crc_ctrl_t         crc_ctrl;
  cfst_pkg::out_item_t         result;

  // APB register access; the word index is paddr[2].
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly <= cfst_pkg::POLY_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == cfst_pkg::REG_CRC_POLY)) begin
      crc_poly <= pwdata[cfst_pkg::CRC_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cfst_pkg::REG_CRC_POLY) begin
      prdata[cfst_pkg::CRC_W-1:0] = crc_poly;
    end
  end

  // Decode the accepted transaction.
  assign accept   = in_valid && in_ready;
  assign do_start = accept && (in_data.mode == cfst_pkg::MODE_START) && !busy;
  assign do_tick  = accept && (in_data.mode == cfst_pkg::MODE_TICK) && busy &&
                    (bits_left != '0);
  assign rx_shift_next = {rx_shift[cfst_pkg::WORD_W-2:0], in_data.rx_bit};

  // Command bits go first; once they are out, the check byte follows from the engine.
  assign crc_ctrl.start = do_start;
  assign crc_ctrl.shift = do_tick && (data_cnt == '0);

  cfst_crc_engine u_crc (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (crc_ctrl),
    .command (in_data.command),
    .poly    (crc_poly),
    .crc_msb (crc_msb)
  );

  // Result of this transaction.
  always_comb begin
    result            = '0;
    result.misuse     = accept && !do_start && !do_tick;
    if (do_tick) begin
      result.tx_bit = (data_cnt != '0) ? data_sr[cfst_pkg::CMD_W-1] : crc_msb;
      if (bits_left == cfst_pkg::CNT_W'(1)) begin
        result.frame_done = 1'b1;
        result.rx_word    = rx_shift_next;
      end
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      bits_left <= '0;
      data_cnt  <= '0;
      rx_shift  <= '0;
      data_sr   <= '0;
    end else if (do_start) begin
      busy      <= 1'b1;
      bits_left <= cfst_pkg::CNT_W'(cfst_pkg::FRAME_BITS);
      data_cnt  <= cfst_pkg::DATA_CNT_W'(cfst_pkg::CMD_W);
      rx_shift  <= '0;
      data_sr   <= {in_data.command[7:0], in_data.command[15:8], in_data.command[23:16]};
    end else if (do_tick) begin
      bits_left <= bits_left - cfst_pkg::CNT_W'(1);
      rx_shift  <= rx_shift_next;
      if (bits_left == cfst_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
      end
      if (data_cnt != '0) begin
        data_cnt <= data_cnt - cfst_pkg::DATA_CNT_W'(1);
        data_sr  <= {data_sr[cfst_pkg::CMD_W-2:0], 1'b0};
      end
    end
  end

  cfst_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_data  (result),
    .load_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
